// ----- rtl/clpr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package clpr_pkg;

   // defaults for the top level parameters
   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int PAGE_BITS_DEF   = 20;

   // fixed field widths of the transactions
   localparam int PAGE_W = 20;
   localparam int CSR_W  = 5;

   // reset value of the residency limit and the largest queue a tick leaves untouched
   localparam logic [CSR_W-1:0] PAGE_LIMIT_RESET = CSR_W'(16);
   localparam int               MIN_FOR_TICK     = 2;

   typedef enum logic [1:0] {
      OP_MAP    = 2'd0,
      OP_ACCESS = 2'd1,
      OP_TICK   = 2'd2,
      OP_EVICT  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      KIND_DONE    = 2'd0,
      KIND_REVOKED = 2'd1,
      KIND_VICTIM  = 2'd2,
      KIND_ERROR   = 2'd3
   } kind_type;

   typedef struct packed {
      op_type              operation;
      logic [PAGE_W-1:0]   page;
   } req_type;

   typedef struct packed {
      kind_type            kind;
      logic [PAGE_W-1:0]   result_page;
      logic                last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RESP,
      ST_ACCESS,
      ST_ACC_DONE,
      ST_TICK,
      ST_TICK_DONE,
      ST_EVICT
   } state_type;

endpackage

`default_nettype wire

// ----- rtl/clock_lru_page_replacement_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Approximate-LRU page queue. Resident pages sit in one synchronous page memory of two
// banks, used as a circular queue, with an accessed flag per slot in flip-flops (cleared
// at reset, so there is no clearing pass). Map, evict and every error or trivial tick
// present their result from the ST_RESP or ST_EVICT state, entered on acceptance, once
// the output register is free; an access scans every resident entry through the single
// memory read port and presents its result from ST_ACC_DONE after the scan; a tick with
// three or more pages walks the queue from tail to head, one entry per cycle unless a
// revoked result is due while the output register is still full, copying each entry
// compacted into the other bank, and presents its done result from ST_TICK_DONE. One transaction is
// worked on at a time; the next is taken as soon as the last result of the previous one
// sits in the output register. The residency limit is taken as the smaller of page_limit
// and QUEUE_DEPTH.
module clock_lru_page_replacement_top #(
   parameter int QUEUE_DEPTH = clpr_pkg::QUEUE_DEPTH_DEF,
   parameter int PAGE_BITS   = clpr_pkg::PAGE_BITS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire clpr_pkg::req_type            req_data,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output clpr_pkg::rsp_type                 rsp_data,
   input  wire logic                         csr_write_enable,
   input  wire logic [clpr_pkg::CSR_W-1:0]   csr_write_data
);

   localparam int IDX_W  = $clog2(QUEUE_DEPTH);
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int ADDR_W = $clog2(2 * QUEUE_DEPTH);
   localparam int CMP_W  = (CNT_W > clpr_pkg::CSR_W) ? CNT_W : clpr_pkg::CSR_W;

   // physical slot helpers for the circular queue
   function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] p);
      return (p == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : p + IDX_W'(1);
   endfunction

   function automatic logic [IDX_W-1:0] wrap_dec(input logic [IDX_W-1:0] p);
      return (p == '0) ? IDX_W'(QUEUE_DEPTH - 1) : p - IDX_W'(1);
   endfunction

   function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
      logic [IDX_W:0] s;
      s = (IDX_W+1)'(a) + (IDX_W+1)'(b);
      if (s >= (IDX_W+1)'(QUEUE_DEPTH)) begin
         s = s - (IDX_W+1)'(QUEUE_DEPTH);
      end
      return s[IDX_W-1:0];
   endfunction

   function automatic logic [ADDR_W-1:0] mem_addr(input logic b, input logic [IDX_W-1:0] i);
      return ADDR_W'(i) + (b ? ADDR_W'(QUEUE_DEPTH) : ADDR_W'(0));
   endfunction

   // state
   clpr_pkg::state_type            state_ff, state_in;
   logic [clpr_pkg::CSR_W-1:0]     page_limit_ff;
   logic [CNT_W-1:0]               count_ff;
   logic [CNT_W-1:0]               flag_cnt_ff;
   logic [IDX_W-1:0]               head_ff;
   logic                           bank_ff;
   logic [QUEUE_DEPTH-1:0]         flags_ff;

   // per transaction working registers
   logic [PAGE_BITS-1:0]           item_page_ff;
   logic [CNT_W-1:0]               left_ff;
   logic [IDX_W-1:0]               iss_p_ff;
   logic [IDX_W-1:0]               pp_ff;
   logic                           found_ff;
   logic [IDX_W-1:0]               last_p_ff;
   logic [CNT_W-1:0]               kept_pos_ff;
   logic [CNT_W-1:0]               moved_pos_ff;
   clpr_pkg::kind_type             resp_kind_ff;

   // output register
   logic                           rsp_valid_ff;
   clpr_pkg::rsp_type              rsp_data_ff;

   // page memory, two banks of QUEUE_DEPTH entries
   logic [PAGE_BITS-1:0]           page_mem [2*QUEUE_DEPTH];
   logic [PAGE_BITS-1:0]           rd_data_ff;
   logic                           rd_en;
   logic [ADDR_W-1:0]              rd_addr;
   logic                           wr_en;
   logic [ADDR_W-1:0]              wr_addr;
   logic [PAGE_BITS-1:0]           wr_data;

   // emission into the output register
   logic                           emit;
   clpr_pkg::rsp_type              emit_data;

   logic                           req_fire;
   logic                           out_free;
   logic                           map_full;
   logic                           cur_flag;
   logic                           tick_stall;
   logic [IDX_W-1:0]               map_slot;
   logic [IDX_W-1:0]               tail_p;
   logic [CNT_W-1:0]               kept_slot;
   logic [PAGE_BITS-1:0]           req_page_int;
   logic [clpr_pkg::PAGE_W-1:0]    rd_page_out;

   // page width conversion between the ports and the stored pages
   if (PAGE_BITS > clpr_pkg::PAGE_W) begin : g_page_wide
      assign req_page_int = {{(PAGE_BITS - clpr_pkg::PAGE_W){1'b0}}, req_data.page};
      assign rd_page_out  = rd_data_ff[clpr_pkg::PAGE_W-1:0];
   end else if (PAGE_BITS == clpr_pkg::PAGE_W) begin : g_page_same
      assign req_page_int = req_data.page;
      assign rd_page_out  = rd_data_ff;
   end else begin : g_page_narrow
      assign req_page_int = req_data.page[PAGE_BITS-1:0];
      assign rd_page_out  = {{(clpr_pkg::PAGE_W - PAGE_BITS){1'b0}}, rd_data_ff};
   end

   // handshake and shared conditions
   assign req_ready  = (state_ff == clpr_pkg::ST_IDLE);
   assign req_fire   = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign map_full   = (count_ff == CNT_W'(QUEUE_DEPTH)) ||
                       (CMP_W'(count_ff) >= CMP_W'(page_limit_ff));
   assign cur_flag   = flags_ff[pp_ff];
   assign tick_stall = (state_ff == clpr_pkg::ST_TICK) && cur_flag && !out_free;
   assign map_slot   = wrap_add(head_ff, count_ff);
   assign tail_p     = wrap_add(head_ff, count_ff - CNT_W'(1));
   assign kept_slot  = kept_pos_ff - CNT_W'(1);

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         clpr_pkg::ST_IDLE: begin
            if (req_fire) begin
               unique case (req_data.operation)
                  clpr_pkg::OP_MAP:    state_in = clpr_pkg::ST_RESP;
                  clpr_pkg::OP_ACCESS: state_in = (count_ff == '0) ? clpr_pkg::ST_RESP
                                                                    : clpr_pkg::ST_ACCESS;
                  clpr_pkg::OP_TICK:   state_in = (count_ff <= CNT_W'(clpr_pkg::MIN_FOR_TICK))
                                                  ? clpr_pkg::ST_RESP : clpr_pkg::ST_TICK;
                  clpr_pkg::OP_EVICT:  state_in = (count_ff == '0) ? clpr_pkg::ST_RESP
                                                                    : clpr_pkg::ST_EVICT;
                  default:             state_in = clpr_pkg::ST_IDLE;
               endcase
            end
         end
         clpr_pkg::ST_ACCESS: begin
            if (left_ff == '0) state_in = clpr_pkg::ST_ACC_DONE;
         end
         clpr_pkg::ST_TICK: begin
            if (!tick_stall && left_ff == '0) state_in = clpr_pkg::ST_TICK_DONE;
         end
         clpr_pkg::ST_RESP, clpr_pkg::ST_ACC_DONE,
         clpr_pkg::ST_TICK_DONE, clpr_pkg::ST_EVICT: begin
            if (out_free) state_in = clpr_pkg::ST_IDLE;
         end
         default: state_in = clpr_pkg::ST_IDLE;
      endcase
   end

   // memory strobes and result emission
   always_comb begin
      rd_en     = 1'b0;
      rd_addr   = mem_addr(bank_ff, head_ff);
      wr_en     = 1'b0;
      wr_addr   = mem_addr(bank_ff, map_slot);
      wr_data   = req_page_int;
      emit      = 1'b0;
      emit_data = '{kind: clpr_pkg::KIND_DONE, result_page: '0, last: 1'b1};
      unique case (state_ff)
         clpr_pkg::ST_IDLE: begin
            if (req_fire) begin
               unique case (req_data.operation)
                  clpr_pkg::OP_MAP: begin
                     wr_en = !map_full;
                  end
                  clpr_pkg::OP_ACCESS, clpr_pkg::OP_EVICT: begin
                     rd_en = (count_ff != '0);
                  end
                  clpr_pkg::OP_TICK: begin
                     rd_en   = (count_ff > CNT_W'(clpr_pkg::MIN_FOR_TICK));
                     rd_addr = mem_addr(bank_ff, tail_p);
                  end
                  default: rd_en = 1'b0;
               endcase
            end
         end
         clpr_pkg::ST_RESP: begin
            emit           = out_free;
            emit_data.kind = resp_kind_ff;
         end
         clpr_pkg::ST_ACCESS: begin
            rd_en   = (left_ff != '0);
            rd_addr = mem_addr(bank_ff, iss_p_ff);
         end
         clpr_pkg::ST_TICK: begin
            // copy the current entry into the other bank, revoked ones go behind the kept
            rd_addr = mem_addr(bank_ff, iss_p_ff);
            wr_data = rd_data_ff;
            wr_addr = cur_flag ? mem_addr(!bank_ff, moved_pos_ff[IDX_W-1:0])
                               : mem_addr(!bank_ff, kept_slot[IDX_W-1:0]);
            if (!tick_stall) begin
               wr_en = 1'b1;
               rd_en = (left_ff != '0);
               emit  = cur_flag;
            end
            emit_data = '{kind: clpr_pkg::KIND_REVOKED, result_page: rd_page_out, last: 1'b0};
         end
         clpr_pkg::ST_ACC_DONE, clpr_pkg::ST_TICK_DONE: begin
            emit = out_free;
         end
         clpr_pkg::ST_EVICT: begin
            emit      = out_free;
            emit_data = '{kind: clpr_pkg::KIND_VICTIM, result_page: rd_page_out, last: 1'b1};
         end
         default: emit = 1'b0;
      endcase
   end

   // page memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         page_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= page_mem[rd_addr];
      end
   end

   // output register payload
   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_data_ff <= emit_data;
      end
   end

   // working registers that carry no control meaning after reset
   always_ff @(posedge clock) begin
      unique case (state_ff)
         clpr_pkg::ST_IDLE: begin
            if (req_fire) begin
               item_page_ff <= req_page_int;
               left_ff      <= count_ff - CNT_W'(1);
               kept_pos_ff  <= count_ff - flag_cnt_ff;
               moved_pos_ff <= count_ff - flag_cnt_ff;
               if (req_data.operation == clpr_pkg::OP_TICK) begin
                  pp_ff    <= tail_p;
                  iss_p_ff <= wrap_dec(tail_p);
               end else begin
                  pp_ff    <= head_ff;
                  iss_p_ff <= wrap_inc(head_ff);
               end
               unique case (req_data.operation)
                  clpr_pkg::OP_MAP:   resp_kind_ff <= map_full ? clpr_pkg::KIND_ERROR
                                                               : clpr_pkg::KIND_DONE;
                  clpr_pkg::OP_EVICT: resp_kind_ff <= clpr_pkg::KIND_ERROR;
                  default:            resp_kind_ff <= clpr_pkg::KIND_DONE;
               endcase
            end
         end
         clpr_pkg::ST_ACCESS: begin
            if (rd_data_ff == item_page_ff) begin
               last_p_ff <= pp_ff;
            end
            if (left_ff != '0) begin
               left_ff  <= left_ff - CNT_W'(1);
               pp_ff    <= iss_p_ff;
               iss_p_ff <= wrap_inc(iss_p_ff);
            end
         end
         clpr_pkg::ST_TICK: begin
            if (!tick_stall) begin
               if (cur_flag) begin
                  moved_pos_ff <= moved_pos_ff + CNT_W'(1);
               end else begin
                  kept_pos_ff <= kept_slot;
               end
               if (left_ff != '0) begin
                  left_ff  <= left_ff - CNT_W'(1);
                  pp_ff    <= iss_p_ff;
                  iss_p_ff <= wrap_dec(iss_p_ff);
               end
            end
         end
         default: begin
         end
      endcase
   end

   // control state: queue shape, flags, limit and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= clpr_pkg::ST_IDLE;
         page_limit_ff <= clpr_pkg::PAGE_LIMIT_RESET;
         count_ff      <= '0;
         flag_cnt_ff   <= '0;
         head_ff       <= '0;
         bank_ff       <= 1'b0;
         flags_ff      <= '0;
         found_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) begin
            page_limit_ff <= csr_write_data;
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            clpr_pkg::ST_IDLE: begin
               found_ff <= 1'b0;
               if (req_fire && req_data.operation == clpr_pkg::OP_MAP && !map_full) begin
                  flags_ff[map_slot] <= 1'b0;
                  count_ff           <= count_ff + CNT_W'(1);
               end
            end
            clpr_pkg::ST_ACCESS: begin
               // keep only the newest matching entry flagged, set once the scan ends
               if (rd_data_ff == item_page_ff) begin
                  found_ff        <= 1'b1;
                  flags_ff[pp_ff] <= 1'b0;
                  if (cur_flag) flag_cnt_ff <= flag_cnt_ff - CNT_W'(1);
               end
            end
            clpr_pkg::ST_ACC_DONE: begin
               if (out_free && found_ff) begin
                  flags_ff[last_p_ff] <= 1'b1;
                  flag_cnt_ff         <= flag_cnt_ff + CNT_W'(1);
               end
            end
            clpr_pkg::ST_TICK_DONE: begin
               // the rebuilt queue lives in the other bank starting at slot zero
               if (out_free) begin
                  bank_ff     <= !bank_ff;
                  head_ff     <= '0;
                  flags_ff    <= '0;
                  flag_cnt_ff <= '0;
               end
            end
            clpr_pkg::ST_EVICT: begin
               if (out_free) begin
                  flags_ff[head_ff] <= 1'b0;
                  if (flags_ff[head_ff]) flag_cnt_ff <= flag_cnt_ff - CNT_W'(1);
                  head_ff  <= wrap_inc(head_ff);
                  count_ff <= count_ff - CNT_W'(1);
               end
            end
            default: begin
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// ----- rtl/clpr_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module clpr_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_valid,
   input wire logic                         req_ready,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_ready,
   input wire clpr_pkg::rsp_type            rsp_data
);

   // transactions accepted whose final result has not been taken yet
   logic [2:0] pend_ff, pend_in;
   logic       req_fire;
   logic       rsp_done;

   assign req_fire = req_valid && req_ready;
   assign rsp_done = rsp_valid && rsp_ready && rsp_data.last;

   always_comb begin
      pend_in = pend_ff + 3'(req_fire) - 3'(rsp_done);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // done and error carry no page
   a_zero_page: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.kind == clpr_pkg::KIND_DONE ||
                    rsp_data.kind == clpr_pkg::KIND_ERROR) |-> rsp_data.result_page == '0)
      else $error("page on done or error result");

   // only revoked results are followed by more results of the same transaction
   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.last == (rsp_data.kind != clpr_pkg::KIND_REVOKED))
      else $error("last flag does not match result kind");

   // no result without an open transaction
   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != '0)
      else $error("result without an accepted transaction");

   // at most one transaction in work and one waiting in the output register
   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff <= 3'd2)
      else $error("too many open transactions");

endmodule

bind clock_lru_page_replacement_top clpr_checker u_clpr_checker (.*);

`default_nettype wire
